// ===== src/polyphonic_sawtooth_mixer_defines.svh =====
// ----------------------------------------------------------------------------
// polyphonic_sawtooth_mixer_defines
// Assertion macros for the sawtooth mixer; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_SAWTOOTH_MIXER_DEFINES_SVH
`define POLYPHONIC_SAWTOOTH_MIXER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define PSM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psm: same-cycle check failed");
// Next-cycle implication.
`define PSM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psm: next-cycle check failed");
`else
`define PSM_ASSERT_IMP(label, clk, rst, ante, cons)
`define PSM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/psm_pkg.sv =====
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, constants and the note step table of the sawtooth mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package psm_pkg;

  localparam int PHASE_W = 32;
  localparam int NOTE_W  = 4;    // wide enough for twelve notes
  localparam int SUM_W   = 14;   // holds +/- 24 * 128
  localparam logic [3:0] MAX_VOLUME = 4'd8;

  // One voice slot presented to the voice ring per cycle.
  typedef struct packed {
    logic              shift;  // rotate the ring by one voice
    logic              key;    // voice sounds this tick
    logic              upper;  // upper bank: double step
    logic [NOTE_W-1:0] note;
  } psm_slot_t;

  // Phase increment per sample for the base octave.
  function automatic logic [PHASE_W-1:0] note_step(input logic [NOTE_W-1:0] n);
    logic [PHASE_W-1:0] s;
    case (n)
      4'd0:    s = 32'd50953930;
      4'd1:    s = 32'd54077542;
      4'd2:    s = 32'd57396381;
      4'd3:    s = 32'd60715219;
      4'd4:    s = 32'd64229283;
      4'd5:    s = 32'd68133799;
      4'd6:    s = 32'd72233540;
      4'd7:    s = 32'd76528508;
      4'd8:    s = 32'd81018701;
      4'd9:    s = 32'd85899345;
      4'd10:   s = 32'd90975216;
      4'd11:   s = 32'd96441538;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== src/psm_voice_ring.sv =====
// ----------------------------------------------------------------------------
// psm_voice_ring
// Circular ring of phase accumulators; one voice advanced per cycle on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_voice_ring #(
  parameter int VOICES = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  psm_pkg::psm_slot_t  slot,
  output logic [7:0]          top,
  output logic                top_vld
);
  import psm_pkg::*;

  logic [PHASE_W-1:0] phase [VOICES];
  logic [PHASE_W-1:0] base_step;
  logic [PHASE_W-1:0] step_val;
  logic [PHASE_W-1:0] sum_ph;
  logic [PHASE_W-1:0] new_ph;

  assign base_step = note_step(slot.note);
  assign step_val  = slot.upper ? {base_step[PHASE_W-2:0], 1'b0} : base_step;
  assign sum_ph    = phase[0] + step_val;
  assign new_ph    = slot.key ? sum_ph : phase[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) phase[i] <= '0;
      top_vld <= 1'b0;
    end else begin
      top_vld <= slot.shift & slot.key;
      if (slot.shift) begin
        for (int i = 0; i < VOICES - 1; i++) phase[i] <= phase[i+1];
        phase[VOICES-1] <= new_ph;
      end
    end
  end

  always_ff @(posedge clk) begin
    top <= sum_ph[PHASE_W-1:PHASE_W-8];
  end

endmodule

`default_nettype wire

// ===== src/psm_mix.sv =====
// ----------------------------------------------------------------------------
// psm_mix
// Signed mix accumulator and volume scaling to an 8-bit offset sample.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_mix (
  input  logic       clk,
  input  logic       clear,
  input  logic       add_en,
  input  logic [7:0] top,
  input  logic [3:0] shift,
  output logic [7:0] mixed
);
  import psm_pkg::*;

  logic signed [SUM_W-1:0] acc;
  logic signed [7:0]       term;
  logic signed [SUM_W-1:0] scaled;

  // top byte minus 128 is the top byte with its msb flipped, read as signed
  assign term = signed'(top ^ 8'h80);

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (add_en) begin
      acc <= acc + {{(SUM_W-8){term[7]}}, term};
    end
  end

  assign scaled = acc >>> shift;
  assign mixed  = scaled[7:0] + 8'd128;

endmodule

`default_nettype wire

// ===== src/polyphonic_sawtooth_mixer.sv =====
// ----------------------------------------------------------------------------
// polyphonic_sawtooth_mixer
// Two banks of sawtooth voices mixed into one unsigned 8-bit sample a tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per audio tick:
//   lower_keys, upper_keys and volume. Output channel (out_valid/out_ready)
//   returns exactly one sample per request, 128 meaning silence.
//   The phases live in a circular shift line of 2*NOTES accumulators; one
//   voice is rotated past a single 32-bit adder per cycle, its key bit taken
//   from a key shift register in step. Volume scaling happens once at the end.
//   in_ready is high only while idle, so the single voice adder walking the
//   ring paces the requests: the next one is taken only after the scale state.
//   A finished sample sits in the output register; the next request is taken
//   while it waits. If the receiver still stalls when the following sample is
//   ready, the block holds in its scale state until the register frees up.
//   Reset clears all phases to zero, drops out_valid and returns to idle;
//   there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyphonic_sawtooth_mixer_defines.svh"

module polyphonic_sawtooth_mixer #(
  parameter int NOTES = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] lower_keys,
  input  logic [11:0] upper_keys,
  input  logic [3:0]  volume,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  sample
);
  import psm_pkg::*;

  localparam int VOICES = 2 * NOTES;
  localparam int NW     = (NOTES > 1) ? $clog2(NOTES) : 1;
  localparam logic [NW-1:0] LAST_NOTE = NW'(NOTES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN,
    ST_SCALE
  } state_t;

  state_t          state;
  logic [VOICES-1:0] keys;      // key bit of the head voice sits at bit 0
  logic [3:0]      shift_amt;
  logic [NW-1:0]   note;
  logic            upper;
  psm_slot_t       slot;
  logic [7:0]      top;
  logic            top_vld;
  logic [7:0]      mixed;
  logic            accept;
  logic [3:0]      vol_shift;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid & in_ready;
  // volume above eight saturates to full scale
  assign vol_shift = (volume > MAX_VOLUME) ? 4'd0 : MAX_VOLUME - volume;

  assign slot.shift = (state == ST_RUN);
  assign slot.key   = keys[0];
  assign slot.upper = upper;
  assign slot.note  = NOTE_W'(note);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      note      <= '0;
      upper     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // in the scale state the output register is reloaded below instead
      if (out_valid && out_ready && state != ST_SCALE) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) state <= ST_RUN;
        end
        ST_RUN: begin
          // walk lower bank then upper bank, wrapping back to the first voice
          if (note == LAST_NOTE) begin
            note  <= '0;
            upper <= ~upper;
            if (upper) state <= ST_FIN;
          end else begin
            note <= note + 1'b1;
          end
        end
        ST_FIN: begin
          state <= ST_SCALE;  // last voice lands in the accumulator here
        end
        ST_SCALE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers: key mask, shift and output sample
  always_ff @(posedge clk) begin
    if (accept) begin
      keys      <= {upper_keys[NOTES-1:0], lower_keys[NOTES-1:0]};
      shift_amt <= vol_shift;
    end else if (state == ST_RUN) begin
      keys <= {1'b0, keys[VOICES-1:1]};
    end
    if (state == ST_SCALE && (!out_valid || out_ready)) sample <= mixed;
  end

  psm_voice_ring #(
    .VOICES (VOICES)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .slot    (slot),
    .top     (top),
    .top_vld (top_vld)
  );

  psm_mix u_mix (
    .clk    (clk),
    .clear  (accept),
    .add_en (top_vld),
    .top    (top),
    .shift  (shift_amt),
    .mixed  (mixed)
  );

  // ring must be back on the first voice once the walk ends
  `PSM_ASSERT_IMP(a_ring_aligned, clk, rst, state == ST_FIN, note == '0 && !upper)
  // a free output register is always loaded when the sample is ready
  `PSM_ASSERT_NXT(a_scale_loads, clk, rst, state == ST_SCALE && !out_valid, out_valid)
  // no voice result may arrive while idle, it would corrupt the next mix
  `PSM_ASSERT_IMP(a_no_stray_add, clk, rst, state == ST_IDLE, !top_vld)

endmodule

`default_nettype wire

// ===== bench/tb_polyphonic_sawtooth_mixer.sv =====
// ----------------------------------------------------------------------------
// tb_polyphonic_sawtooth_mixer
// Self-checking bench for the sawtooth mixer. Each accepted request is run
// through a local model of the 24 phase accumulators, and the predicted sample
// is queued. A monitor compares every sample the block returns against the
// oldest prediction. Directed cases cover silence, full chords, walking keys
// and volume saturation. Random chords are held over runs of ticks, with
// random gaps on the request side and random stalls on the sample side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_polyphonic_sawtooth_mixer;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_NOTES  = 12;
  localparam int NUM_VOICES = 2 * NUM_NOTES;
  localparam int RANDOM_TICKS = 1400;

  // Base-octave phase increments. The upper bank uses twice these.
  localparam logic [31:0] BASE_STEP [NUM_NOTES] = '{
    32'd50953930, 32'd54077542, 32'd57396381, 32'd60715219,
    32'd64229283, 32'd68133799, 32'd72233540, 32'd76528508,
    32'd81018701, 32'd85899345, 32'd90975216, 32'd96441538
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [11:0] lower_keys;
  logic [11:0] upper_keys;
  logic [3:0]  volume;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  sample;

  // Model state: lower bank in 0..11, upper bank in 12..23.
  logic [31:0] model_phase [NUM_VOICES];
  logic [7:0]  pending_samples [$];
  int          mismatches;
  int          ticks_sent;
  bit          quiet;        // no gaps or new stalls while set

  polyphonic_sawtooth_mixer DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .lower_keys (lower_keys),
    .upper_keys (upper_keys),
    .volume     (volume),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample     (sample)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // --------------------------------------------------------------------------
  // Model of one tick: advance the sounding voices, mix, scale, re-bias.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] mix_tick(input logic [11:0] lo, input logic [11:0] up,
                                          input logic [3:0] vol);
    logic [31:0] acc;
    logic [31:0] ph;
    logic [31:0] scaled;
    logic [3:0]  lvl;
    acc = '0;
    for (int n = 0; n < NUM_NOTES; n++) begin
      if (lo[n]) begin
        ph = model_phase[n] + BASE_STEP[n];
        model_phase[n] = ph;
        acc = acc + {24'd0, ph[31:24]} - 32'd128;
      end
    end
    for (int n = 0; n < NUM_NOTES; n++) begin
      if (up[n]) begin
        ph = model_phase[NUM_NOTES + n] + (BASE_STEP[n] << 1);
        model_phase[NUM_NOTES + n] = ph;
        acc = acc + {24'd0, ph[31:24]} - 32'd128;
      end
    end
    // levels above eight saturate; only the low byte survives, so a logical
    // shift gives the same bits as an arithmetic one
    lvl = (vol > psm_pkg::MAX_VOLUME) ? psm_pkg::MAX_VOLUME : vol;
    scaled = acc >> (4'd8 - lvl);
    return scaled[7:0] + 8'd128;
  endfunction

  // Mostly short idle spells, now and then a long one.
  function automatic int idle_len(input int longest);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, longest);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Request side. Entered and left at a falling edge. Valid is only lowered
  // when a gap is taken, so it is never dropped and raised in one step.
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic [11:0] lo, input logic [11:0] up,
                           input logic [3:0] vol);
    int gap;
    gap = quiet ? 0 : idle_len(60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    lower_keys <= lo;
    upper_keys <= up;
    volume     <= vol;
    do @(posedge clk); while (!in_ready);
    pending_samples.push_back(mix_tick(lo, up, vol));
    ticks_sent++;
    @(negedge clk);
  endtask

  // Every request yields a sample, so an empty queue means the block is idle.
  task automatic wait_for_samples();
    while (pending_samples.size() != 0) @(negedge clk);
  endtask

  function automatic logic [11:0] pick_keys();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 12'h000;
    if (r < 24) return 12'hFFF;
    if (r < 55) return 12'($urandom() & $urandom() & $urandom());   // sparse
    return 12'($urandom());
  endfunction

  function automatic logic [3:0] pick_volume();
    if ($urandom_range(0, 4) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, 8));
  endfunction

  // Sample side: ready drops for random spells; none start while quiet.
  initial begin
    int stall_left;
    stall_left = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall_left = idle_len(80);
      end
    end
  end

  // Monitor: each accepted sample against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("sample with no request outstanding", sample, 8'd0);
      end else begin
        logic [7:0] want;
        want = pending_samples.pop_front();
        if (sample !== want) report_mismatch("sample", sample, want);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // No keys: silence whatever the volume.
  task automatic test_silence();
    send_tick(12'h000, 12'h000, 4'd0);
    send_tick(12'h000, 12'h000, 4'd8);
    send_tick(12'h000, 12'h000, 4'd15);
  endtask

  // Full and one-bank chords; the mix can overflow the sample byte and wrap.
  task automatic test_full_chord();
    repeat (3) send_tick(12'hFFF, 12'hFFF, 4'd8);
    send_tick(12'hFFF, 12'hFFF, 4'd0);
    send_tick(12'hFFF, 12'hFFF, 4'd15);
    send_tick(12'hFFF, 12'h000, 4'd4);
    send_tick(12'h000, 12'hFFF, 4'd12);
  endtask

  // One key per bank, walking in opposite directions; volume sweeps 4..15
  // so the saturating levels come in too.
  task automatic test_walking_keys();
    for (int n = 0; n < NUM_NOTES; n++)
      send_tick(12'h001 << n, 12'h800 >> n, 4'(n + 4));
  endtask

  // Sender holds off until everything outstanding has come back.
  task automatic test_drain_pause();
    repeat (40) send_tick(pick_keys(), pick_keys(), pick_volume());
    in_valid <= 1'b0;
    wait_for_samples();
    repeat (40) send_tick(pick_keys(), pick_keys(), pick_volume());
  endtask

  // Chords held for runs of ticks so the phases build up; some runs are sent
  // back to back with no new stalls on the receiver.
  task automatic test_random_chords();
    logic [11:0] lo;
    logic [11:0] up;
    logic [3:0]  vol;
    int          hold;
    while (ticks_sent < RANDOM_TICKS) begin
      lo    = pick_keys();
      up    = pick_keys();
      vol   = pick_volume();
      hold  = $urandom_range(1, 24);
      quiet = ($urandom_range(0, 7) == 0);
      for (int t = 0; t < hold; t++) begin
        if ($urandom_range(0, 5) == 0) vol = pick_volume();
        send_tick(lo, up, vol);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    lower_keys = '0;
    upper_keys = '0;
    volume     = '0;
    out_ready  = 1'b0;
    quiet      = 1'b0;
    mismatches = 0;
    ticks_sent = 0;
    for (int v = 0; v < NUM_VOICES; v++) model_phase[v] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_silence();
    test_full_chord();
    test_walking_keys();
    test_drain_pause();
    test_random_chords();

    in_valid <= 1'b0;
    wait_for_samples();
    repeat (40) @(posedge clk);

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
